@@ rtl/atpr_pkg.sv @@
// ----------------------------------------------------------------------------
// atpr_pkg
// Shared constants, types and the arctangent table for the tilt angle core.
// ----------------------------------------------------------------------------
package atpr_pkg;

	// Sample and fixed-point formats
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 32 - SAMPLE_BITS;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int RAD_W       = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int REM_W       = ROOT_W + 4;
	localparam int DIGITS_PER  = 2;
	localparam int SQRT_STAGES = ROOT_W / DIGITS_PER;

	// Normalization and rotation
	localparam int NORM_MSB     = 40;
	localparam int SHIFT_W      = 6;
	localparam int VEC_W        = 46;
	localparam int CORDIC_STEPS = 24;
	localparam int ACC_W        = 28;
	localparam int ANGLE_FULL   = 9000 * 4096;
	localparam int ROUND_HALF   = 2048;
	localparam int ROUND_SHIFT  = 12;
	localparam int OUT_W        = 15;
	localparam int MAX_CDEG     = 9000;

	// Square, sum, root, two normalize stages, rotations, output stage
	localparam int LATENCY = 2 + SQRT_STAGES + 2 + CORDIC_STEPS + 1;

	typedef struct packed {
		logic                    valid;
		logic signed [OUT_W-1:0] angle;
	} angle_res_t;

	// atan(2^-i) in units of 1/4096 centidegree, rounded
	function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
		logic signed [ACC_W-1:0] v;
		case (i)
			0:  v = 28'sd18432000;
			1:  v = 28'sd10881045;
			2:  v = 28'sd5749245;
			3:  v = 28'sd2918407;
			4:  v = 28'sd1464867;
			5:  v = 28'sd733147;
			6:  v = 28'sd366663;
			7:  v = 28'sd183343;
			8:  v = 28'sd91673;
			9:  v = 28'sd45837;
			10: v = 28'sd22918;
			11: v = 28'sd11459;
			12: v = 28'sd5730;
			13: v = 28'sd2865;
			14: v = 28'sd1432;
			15: v = 28'sd716;
			16: v = 28'sd358;
			17: v = 28'sd179;
			18: v = 28'sd90;
			19: v = 28'sd45;
			20: v = 28'sd22;
			21: v = 28'sd11;
			22: v = 28'sd6;
			23: v = 28'sd3;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/atpr_angle.sv @@
// ----------------------------------------------------------------------------
// atpr_angle
// Pipelined atan2(num, sqrt(p^2 + q^2)) in centidegrees: squares, a
// two-digit-per-stage floor square root, normalization, unrolled CORDIC.
// ----------------------------------------------------------------------------
module atpr_angle import atpr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] num,
	input  logic signed [SAMPLE_BITS-1:0] p,
	input  logic signed [SAMPLE_BITS-1:0] q,
	output angle_res_t                    res
);

	// Stage 1: squares
	logic                          v_s1;
	logic signed [SQ_W-1:0]        pp_s1, qq_s1;
	logic signed [SAMPLE_BITS-1:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		pp_s1  <= p * p;
		qq_s1  <= q * q;
		num_s1 <= num;
	end

	// Stage 2: sum of squares, magnitude and sign of the numerator
	logic signed [SAMPLE_BITS:0] num_ext;
	logic signed [SAMPLE_BITS:0] num_abs;
	assign num_ext = {num_s1[SAMPLE_BITS-1], num_s1};
	assign num_abs = num_ext[SAMPLE_BITS] ? -num_ext : num_ext;

	// Root pipeline taps; index 0 is stage 2
	logic                   sv  [0:SQRT_STAGES];
	logic [RAD_W-1:0]       rad [0:SQRT_STAGES];
	logic [REM_W-1:0]       rem [0:SQRT_STAGES];
	logic [ROOT_W-1:0]      rt  [0:SQRT_STAGES];
	logic [SAMPLE_BITS-1:0] mg  [0:SQRT_STAGES];
	logic                   ng  [0:SQRT_STAGES];
	logic                   zr  [0:SQRT_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sv[0] <= 1'b0;
		else         sv[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		rad[0] <= {SQ_W'(pp_s1) + SQ_W'(qq_s1), {(2*FRAC_BITS){1'b0}}};
		rem[0] <= '0;
		rt[0]  <= '0;
		mg[0]  <= num_abs[SAMPLE_BITS-1:0];
		ng[0]  <= num_s1[SAMPLE_BITS-1];
		zr[0]  <= (num_s1 == '0);
	end

	// Root stages: two result digits each
	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
		logic [RAD_W-1:0]  rad_n;
		logic [REM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] rt_n;

		always_comb begin
			logic [REM_W-1:0] r, t;
			rad_n = rad[j];
			rem_n = rem[j];
			rt_n  = rt[j];
			for (int d = 0; d < DIGITS_PER; d++) begin
				r = {rem_n[REM_W-3:0], rad_n[RAD_W-1 -: 2]};
				t = {2'b00, rt_n, 2'b01};
				if (r >= t) begin
					rem_n = r - t;
					rt_n  = {rt_n[ROOT_W-2:0], 1'b1};
				end else begin
					rem_n = r;
					rt_n  = {rt_n[ROOT_W-2:0], 1'b0};
				end
				rad_n = {rad_n[RAD_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[j+1] <= 1'b0;
			else         sv[j+1] <= sv[j];
		end

		always_ff @(posedge clk) begin
			rad[j+1] <= rad_n;
			rem[j+1] <= rem_n;
			rt[j+1]  <= rt_n;
			mg[j+1]  <= mg[j];
			ng[j+1]  <= ng[j];
			zr[j+1]  <= zr[j];
		end
	end

	// Normalize A: find the leading one of the larger operand
	logic [ROOT_W-1:0] mag_w;
	logic [ROOT_W-1:0] big;
	logic [SHIFT_W-1:0] msb;
	assign mag_w = {mg[SQRT_STAGES], {FRAC_BITS{1'b0}}};
	assign big   = (mag_w > rt[SQRT_STAGES]) ? mag_w : rt[SQRT_STAGES];

	always_comb begin
		msb = '0;
		for (int b = 0; b < ROOT_W; b++) begin
			if (big[b]) msb = SHIFT_W'(b);
		end
	end

	logic               v_na_q;
	logic [ROOT_W-1:0]  mag_na_q, den_na_q;
	logic [SHIFT_W-1:0] sh_na_q;
	logic               neg_na_q, zero_na_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_na_q <= 1'b0;
		else         v_na_q <= sv[SQRT_STAGES];
	end

	always_ff @(posedge clk) begin
		mag_na_q  <= mag_w;
		den_na_q  <= rt[SQRT_STAGES];
		sh_na_q   <= SHIFT_W'(NORM_MSB) - msb;
		neg_na_q  <= ng[SQRT_STAGES];
		zero_na_q <= zr[SQRT_STAGES];
	end

	// Normalize B: shift both operands together; index 0 feeds the CORDIC
	logic                    cv  [0:CORDIC_STEPS];
	logic signed [VEC_W-1:0] vx  [0:CORDIC_STEPS];
	logic signed [VEC_W-1:0] vy  [0:CORDIC_STEPS];
	logic signed [ACC_W-1:0] acc [0:CORDIC_STEPS];
	logic                    cn  [0:CORDIC_STEPS];
	logic                    cz  [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv[0] <= 1'b0;
		else         cv[0] <= v_na_q;
	end

	always_ff @(posedge clk) begin
		vx[0]  <= VEC_W'(den_na_q) << sh_na_q;
		vy[0]  <= VEC_W'(mag_na_q) << sh_na_q;
		acc[0] <= '0;
		cn[0]  <= neg_na_q;
		cz[0]  <= zero_na_q;
	end

	// Rotation stages: one vectoring step each
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [VEC_W-1:0] dx, dy;
		assign dx = vy[i] >>> i;
		assign dy = vx[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv[i+1] <= 1'b0;
			else         cv[i+1] <= cv[i];
		end

		always_ff @(posedge clk) begin
			if (!vy[i][VEC_W-1]) begin
				vx[i+1]  <= vx[i] + dx;
				vy[i+1]  <= vy[i] - dy;
				acc[i+1] <= acc[i] + atan_entry(i);
			end else begin
				vx[i+1]  <= vx[i] - dx;
				vy[i+1]  <= vy[i] + dy;
				acc[i+1] <= acc[i] - atan_entry(i);
			end
			cn[i+1] <= cn[i];
			cz[i+1] <= cz[i];
		end
	end

	// Output: clamp, round to nearest, restore the sign
	logic signed [ACC_W-1:0] acc_cl;
	logic [ACC_W-1:0]        acc_rnd;
	logic signed [OUT_W-1:0] mag_out;

	always_comb begin
		acc_cl = acc[CORDIC_STEPS];
		if (acc_cl < 0) acc_cl = '0;
		if (acc_cl > ACC_W'(ANGLE_FULL)) acc_cl = ACC_W'(ANGLE_FULL);
		acc_rnd = ACC_W'(acc_cl) + ACC_W'(ROUND_HALF);
		mag_out = OUT_W'(acc_rnd >> ROUND_SHIFT);
	end

	logic                    v_out_q;
	logic signed [OUT_W-1:0] ang_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else         v_out_q <= cv[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (cz[CORDIC_STEPS])      ang_out_q <= '0;
		else if (cn[CORDIC_STEPS]) ang_out_q <= -mag_out;
		else                       ang_out_q <= mag_out;
	end

	assign res.valid = v_out_q;
	assign res.angle = ang_out_q;

endmodule

@@ rtl/accel_tilt_pitch_roll_core.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_core
// Pitch and roll from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Usage:
//   Drive accel_x, accel_y, accel_z and raise start for one cycle per
//   request; a request is taken at each rising edge with start high and
//   busy low. busy stays low: the pipeline takes one request every cycle.
//   Each request gives one result: done is high for exactly one cycle with
//   pitch_centideg and roll_centideg (0.01 degree, -9000..9000, rounded).
//   Requests pass through squaring, the 16 square-root stages (two digits
//   per stage), normalization, the 24 CORDIC rotation stages and rounding.
//   Throughput is one sample per cycle.
//   Reset clears all stage valid bits; requests in flight are dropped.
//   Results are shown once and must be captured in that cycle.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_core import atpr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic                          done,
	output logic signed [OUT_W-1:0]       pitch_centideg,
	output logic signed [OUT_W-1:0]       roll_centideg
);

	logic       req;
	angle_res_t pitch_res, roll_res;

	// Never hold off: every stage advances each cycle
	assign busy = 1'b0;
	assign req  = start & ~busy;

	// Pitch: x against the y-z pair
	atpr_angle u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req),
		.num      (accel_x),
		.p        (accel_y),
		.q        (accel_z),
		.res      (pitch_res)
	);

	// Roll: y against the x-z pair
	atpr_angle u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req),
		.num      (accel_y),
		.p        (accel_x),
		.q        (accel_z),
		.res      (roll_res)
	);

	assign done           = pitch_res.valid;
	assign pitch_centideg = pitch_res.angle;
	assign roll_centideg  = roll_res.angle;

	// Both angle pipelines stay in step
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_res.valid == roll_res.valid)
		else $error("pitch and roll valid differ");

	// Every request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##LATENCY done)
		else $error("result missing after pipeline latency");

	// Results stay within a quarter turn
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_centideg <= MAX_CDEG && pitch_centideg >= -MAX_CDEG))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll_centideg <= MAX_CDEG && roll_centideg >= -MAX_CDEG))
		else $error("roll out of range");

endmodule

@@ dv/tilt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_checker
// Watches requests and results of the tilt angle core, computes the expected
// pitch and roll with an integer square root and vectoring CORDIC, and
// compares each result in order with the oldest expected one.
// ----------------------------------------------------------------------------
module tilt_checker import atpr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic                          done,
	input  logic signed [OUT_W-1:0]       pitch_centideg,
	input  logic signed [OUT_W-1:0]       roll_centideg,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic signed [OUT_W-1:0] pitch;
		logic signed [OUT_W-1:0] roll;
	} tilt_t;

	tilt_t angle_q[$];

	localparam longint TILT_ATAN [CORDIC_STEPS] = '{
		18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
		91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
		358, 179, 90, 45, 22, 11, 6, 3
	};

	// Floor square root, digit by digit
	function automatic longint unsigned isqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// atan2(num, sqrt(p^2+q^2)) in centidegrees
	function automatic longint tilt_cdeg(input longint num, input longint p,
			input longint q);
		longint unsigned sumsq;
		longint den, mag, big, vx, vy, dx, dy, acc, r;
		sumsq = longint'(p * p) + longint'(q * q);
		den = longint'(isqrt(sumsq << (2 * FRAC_BITS)));
		mag = (num < 0 ? -num : num) <<< FRAC_BITS;
		acc = 0;
		big = mag > den ? mag : den;
		if (big == 0 || mag == 0) return 0;
		while (big < (64'sd1 <<< NORM_MSB)) begin
			big *= 2;
			mag *= 2;
			den *= 2;
		end
		vx = den;
		vy = mag;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx;
				vy -= dy;
				acc += TILT_ATAN[i];
			end else begin
				vx -= dx;
				vy += dy;
				acc -= TILT_ATAN[i];
			end
		end
		if (acc < 0) acc = 0;
		if (acc > ANGLE_FULL) acc = ANGLE_FULL;
		r = (acc + ROUND_HALF) >>> ROUND_SHIFT;
		return num < 0 ? -r : r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = angle_q.size();

	initial errors = 0;

	// Predict on each accepted request, compare on each result
	always @(posedge clk) begin
		tilt_t want;
		if (arst_n) begin
			if (done) begin
				if (angle_q.size() == 0) begin
					report("unexpected result", pitch_centideg, 0);
				end else begin
					want = angle_q.pop_front();
					if (pitch_centideg !== want.pitch)
						report("pitch", pitch_centideg, want.pitch);
					if (roll_centideg !== want.roll)
						report("roll", roll_centideg, want.roll);
				end
			end
			if (start && !busy) begin
				want.pitch = OUT_W'(tilt_cdeg(accel_x, accel_y, accel_z));
				want.roll  = OUT_W'(tilt_cdeg(accel_y, accel_x, accel_z));
				angle_q.push_back(want);
			end
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the tilt angle core: directed extreme samples, then random
// samples with random gaps; a checker instance predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import atpr_pkg::*;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic signed [SAMPLE_BITS-1:0] accel_x, accel_y, accel_z;
	logic                          done;
	logic signed [OUT_W-1:0]       pitch_centideg, roll_centideg;
	int                            errors, pending;

	accel_tilt_pitch_roll_core uut (.*);
	tilt_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Pick one axis value: extremes, small values, or full range
	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			3: return 16'd0;
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold one request until accepted
	task automatic send(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		start   <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	localparam logic [15:0] DIR [15][3] = '{
		'{16'h0000, 16'h0000, 16'h0000}, '{16'h7fff, 16'h0000, 16'h0000},
		'{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h7fff, 16'h0000},
		'{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0000, 16'h7fff},
		'{16'h0000, 16'h0000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
		'{16'h8000, 16'h8000, 16'h8000}, '{16'h8000, 16'h7fff, 16'h0001},
		'{16'h0001, 16'h0001, 16'h0001}, '{16'hffff, 16'hffff, 16'hffff},
		'{16'h1000, 16'h0000, 16'h1000}, '{16'h7fff, 16'h8000, 16'h0000},
		'{16'h0001, 16'h0000, 16'h0000}
	};

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 15; i++) send(DIR[i][0], DIR[i][1], DIR[i][2]);
		// Random part: gaps in the first stretch, back to back at the end
		for (int n = 0; n < 900; n++) begin
			if (n < 700 && $urandom_range(0, 3) == 0) idle_burst();
			if ($urandom_range(0, 1)) send(16'($urandom), 16'($urandom), 16'($urandom));
			else send(pick_axis(), pick_axis(), pick_axis());
		end
		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
